[hdl/spq_pkg.sv]
`default_nettype none

package spq_pkg;

	localparam int unsigned ValueWidth = 32;
	localparam int unsigned CountWidth = 5;

	typedef enum logic {
		FUNC_PUSH = 1'b0,
		FUNC_POP  = 1'b1
	} spq_func_t;

	typedef struct packed {
		spq_func_t                     func;
		logic signed [ValueWidth-1:0]  value;
	} spq_in_t;

	typedef struct packed {
		logic signed [ValueWidth-1:0]  top_value;
		logic signed [ValueWidth-1:0]  removed_value;
		logic [CountWidth-1:0]         count;
		logic                          empty_res;
		logic                          overflow;
	} spq_out_t;

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} spq_state_t;

	typedef struct packed {
		logic capture;
		logic execute;
	} spq_ctrl_t;

endpackage

`default_nettype wire

[hdl/spq_chan_if.sv]
`default_nettype none

interface spq_chan_if #(
	parameter type data_t = logic
);
	logic  valid;
	logic  ready;
	data_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

`default_nettype wire

[hdl/spq_ctrl.sv]
`default_nettype none

module spq_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cmd_valid,
	output logic               cmd_ready,
	output logic               res_valid,
	input  wire logic          res_ready,
	output spq_pkg::spq_ctrl_t ctl
);
	import spq_pkg::*;

	spq_state_t state_q;
	spq_state_t state_nxt;
	logic       res_valid_q;
	logic       res_free;

	assign res_free  = !res_valid_q || res_ready;
	assign res_valid = res_valid_q;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					state_nxt = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (res_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd_ready   = 1'b0;
		ctl.capture = 1'b0;
		ctl.execute = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				cmd_ready   = 1'b1;
				ctl.capture = cmd_valid;
			end
			ST_EXEC: begin
				ctl.execute = res_free;
			end
			default: begin
				cmd_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (ctl.execute) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

[hdl/spq_datapath.sv]
`default_nettype none

module spq_datapath #(
	parameter int unsigned DEPTH = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire spq_pkg::spq_ctrl_t ctl,
	input  wire spq_pkg::spq_in_t  cmd_data,
	output spq_pkg::spq_out_t      res_data
);
	import spq_pkg::*;

	localparam int unsigned OccWidth = $clog2(DEPTH + 1);

	logic signed [ValueWidth-1:0] entries_q [DEPTH];
	logic signed [ValueWidth-1:0] entries_nxt [DEPTH];
	logic [OccWidth-1:0]          occ_q;
	logic [OccWidth-1:0]          occ_nxt;
	spq_func_t                    func_q;
	logic signed [ValueWidth-1:0] value_q;
	spq_out_t                     res_q;
	spq_out_t                     res_nxt;
	logic [DEPTH-1:0]             ge;
	logic [DEPTH-1:0]             ge_prev;
	logic                         full;
	logic                         is_empty;
	logic [OccWidth+CountWidth-1:0] occ_ext;

	assign full     = (occ_q == OccWidth'(DEPTH));
	assign is_empty = (occ_q == '0);

	// A slot holds its entry when it is live and not below the new value;
	// sorted order makes these flags a run of ones from slot zero.
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			ge[i] = (OccWidth'(i) < occ_q) && (entries_q[i] >= value_q);
		end
		ge_prev[0] = 1'b1;
		for (int i = 1; i < DEPTH; i++) begin
			ge_prev[i] = ge[i-1];
		end
	end

	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			entries_nxt[i] = entries_q[i];
		end
		occ_nxt = occ_q;
		res_nxt.removed_value = '0;
		res_nxt.overflow      = 1'b0;
		case (func_q)
			FUNC_PUSH: begin
				if (full) begin
					res_nxt.overflow = 1'b1;
				end else begin
					for (int i = 0; i < DEPTH; i++) begin
						if (ge[i]) begin
							entries_nxt[i] = entries_q[i];
						end else if (ge_prev[i]) begin
							entries_nxt[i] = value_q;
						end else if (i > 0) begin
							entries_nxt[i] = entries_q[i-1];
						end
					end
					occ_nxt = occ_q + 1'b1;
				end
			end
			FUNC_POP: begin
				if (!is_empty) begin
					res_nxt.removed_value = entries_q[0];
					for (int i = 0; i < DEPTH - 1; i++) begin
						entries_nxt[i] = entries_q[i+1];
					end
					occ_nxt = occ_q - 1'b1;
				end
			end
			default: begin
				occ_nxt = occ_q;
			end
		endcase
		occ_ext           = {{CountWidth{1'b0}}, occ_nxt};
		res_nxt.count     = occ_ext[CountWidth-1:0];
		res_nxt.empty_res = (occ_nxt == '0);
		res_nxt.top_value = (occ_nxt == '0) ? '0 : entries_nxt[0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else if (ctl.execute) begin
			occ_q <= occ_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			func_q  <= cmd_data.func;
			value_q <= cmd_data.value;
		end
		if (ctl.execute) begin
			res_q <= res_nxt;
			for (int i = 0; i < DEPTH; i++) begin
				entries_q[i] <= entries_nxt[i];
			end
		end
	end

	assign res_data = res_q;

endmodule

`default_nettype wire

[hdl/sorted_priority_queue_top.sv]
`default_nettype none

// Channel  Role    Payload
// -------  ------  ------------------------------------------------------
// cmd      sink    func, value
// res      source  top_value, removed_value, count, empty_res, overflow
//
// Every operation has a capture step that takes the transfer on cmd and
// an execute step in which all entries compare with the value and shift
// in parallel. A finished result waits in the output register while the
// next cmd transfer is taken; the update stalls only while that register
// is full. Reset empties the queue; entry storage is not cleared.

module sorted_priority_queue_top #(
	parameter int unsigned DEPTH = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	spq_chan_if.sink   cmd,
	spq_chan_if.source res
);
	import spq_pkg::*;

	spq_ctrl_t ctl;

	spq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd.valid),
		.cmd_ready (cmd.ready),
		.res_valid (res.valid),
		.res_ready (res.ready),
		.ctl       (ctl)
	);

	spq_datapath #(
		.DEPTH (DEPTH)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.cmd_data (cmd.data),
		.res_data (res.data)
	);

endmodule

`default_nettype wire

[verif/tb_top.sv]
`default_nettype none

module tb_top;
	import spq_pkg::*;

	localparam int unsigned QueueDepth  = 16;
	localparam int unsigned RandomItems = 1600;
	localparam int unsigned IdleLimit   = 1000;
	localparam int unsigned TailCycles  = 8;

	typedef enum int {
		RX_OPEN,
		RX_COIN,
		RX_PERIODIC,
		RX_BURSTY
	} rx_mode_t;

	class spq_scoreboard;
		logic signed [ValueWidth-1:0] slots [QueueDepth];
		int unsigned                  fill;
		spq_out_t                     awaited [$];
		int unsigned                  mismatches;

		function new();
			fill = 0;
			mismatches = 0;
		endfunction

		function void note_cmd(spq_in_t item);
			spq_out_t                     r;
			logic signed [ValueWidth-1:0] v;
			int unsigned                  pos;
			int unsigned                  i;
			r = '0;
			v = item.value;
			if (item.func == FUNC_PUSH) begin
				if (fill >= QueueDepth) begin
					r.overflow = 1'b1;
				end else begin
					pos = 0;
					while (pos < fill && slots[pos] >= v)
						pos++;
					for (i = fill; i > pos; i--)
						slots[i] = slots[i-1];
					slots[pos] = v;
					fill++;
				end
			end else if (fill > 0) begin
				r.removed_value = slots[0];
				for (i = 1; i < fill; i++)
					slots[i-1] = slots[i];
				fill--;
			end
			r.top_value = (fill > 0) ? slots[0] : '0;
			r.count = CountWidth'(fill);
			r.empty_res = (fill == 0);
			awaited.push_back(r);
		endfunction

		function void check_res(spq_out_t got);
			spq_out_t want;
			bit       bad;
			if (awaited.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Result transfer with nothing expected: top %0d removed %0d count %0d",
						got.top_value, got.removed_value, got.count);
				return;
			end
			want = awaited.pop_front();
			bad = (got.top_value !== want.top_value) ||
				(got.removed_value !== want.removed_value) ||
				(got.count !== want.count) ||
				(got.empty_res !== want.empty_res) ||
				(got.overflow !== want.overflow);
			if (bad) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("Mismatch: expected top %0d removed %0d count %0d empty %0b ovf %0b",
						want.top_value, want.removed_value, want.count, want.empty_res,
						want.overflow);
					$display("          actual   top %0d removed %0d count %0d empty %0b ovf %0b",
						got.top_value, got.removed_value, got.count, got.empty_res,
						got.overflow);
				end
			end
		endfunction

		function int unsigned pending();
			return awaited.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;

	spq_chan_if #(.data_t(spq_in_t))  cmd_ch ();
	spq_chan_if #(.data_t(spq_out_t)) res_ch ();

	sorted_priority_queue_top #(
		.DEPTH(QueueDepth)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.res    (res_ch)
	);

	spq_scoreboard sb;

	int unsigned burst_left;
	int unsigned idle_cycles;

	rx_mode_t    rx_mode;
	int unsigned rx_left;
	int unsigned rx_period;
	int unsigned rx_duty;
	int unsigned rx_phase;
	int unsigned rx_hold;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial begin
		sb = new();
		arst_n = 1'b0;
		cmd_ch.valid = 1'b0;
		cmd_ch.data = '0;
		res_ch.ready = 1'b0;
		burst_left = 0;
		rx_mode = RX_OPEN;
		rx_left = 0;
		rx_period = 2;
		rx_duty = 1;
		rx_phase = 0;
		rx_hold = 0;
	end

	function automatic logic signed [ValueWidth-1:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2, 3: return $signed($urandom_range(0, 8)) - 4;
			default: return $signed($urandom());
		endcase
	endfunction

	task automatic send_cmd(input spq_func_t func, input logic signed [ValueWidth-1:0] value);
		spq_in_t     item;
		int unsigned gap;
		item.func = func;
		item.value = value;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap != 0) begin
				cmd_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 250)
				: $urandom_range(1, 40);
		end
		burst_left--;
		cmd_ch.valid <= 1'b1;
		cmd_ch.data <= item;
		do @(posedge clk); while (!cmd_ch.ready);
		sb.note_cmd(item);
	endtask

	task automatic drain_results();
		cmd_ch.valid <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	always @(posedge clk) begin
		if (res_ch.valid && res_ch.ready)
			sb.check_res(res_ch.data);
		if (rx_left == 0) begin
			rx_mode = rx_mode_t'($urandom_range(0, 3));
			rx_left = $urandom_range(30, 300);
			rx_period = $urandom_range(2, 12);
			rx_duty = $urandom_range(1, rx_period - 1);
			rx_phase = 0;
			rx_hold = 0;
		end else begin
			rx_left--;
		end
		case (rx_mode)
			RX_OPEN: begin
				res_ch.ready <= 1'b1;
			end
			RX_COIN: begin
				res_ch.ready <= 1'($urandom_range(0, 1));
			end
			RX_PERIODIC: begin
				res_ch.ready <= (rx_phase < rx_duty);
				rx_phase = (rx_phase + 1) % rx_period;
			end
			default: begin
				if (rx_hold > 0) begin
					res_ch.ready <= 1'b0;
					rx_hold--;
				end else begin
					res_ch.ready <= 1'b1;
					if ($urandom_range(0, 15) == 0)
						rx_hold = $urandom_range(5, 20);
				end
			end
		endcase
	end

	initial begin
		idle_cycles = 0;
		while (idle_cycles < IdleLimit) begin
			@(posedge clk);
			if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("tb_top: FAIL");
		$finish;
	end

	initial begin
		int unsigned n;
		int unsigned seg_left;
		int unsigned push_pct;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: pop on empty, extremes, equal values, filling up and overflow.
		send_cmd(FUNC_POP, 32'sh12345678);
		send_cmd(FUNC_PUSH, 32'sh7fffffff);
		send_cmd(FUNC_PUSH, 32'sh80000000);
		send_cmd(FUNC_PUSH, 32'sh0);
		send_cmd(FUNC_PUSH, 32'sh0);
		send_cmd(FUNC_PUSH, -32'sd1);
		send_cmd(FUNC_POP, 32'sh0);
		send_cmd(FUNC_POP, -32'sd1);
		for (n = 0; n < 13; n++)
			send_cmd(FUNC_PUSH, $signed(n % 5) * 7 - 14);
		send_cmd(FUNC_PUSH, 32'sh7fffffff);
		send_cmd(FUNC_POP, 32'sh0);
		drain_results();

		seg_left = 0;
		push_pct = 50;
		for (n = 0; n < RandomItems; n++) begin
			if (seg_left == 0) begin
				seg_left = $urandom_range(20, 80);
				case ($urandom_range(0, 2))
					0: push_pct = 90;
					1: push_pct = 50;
					default: push_pct = 10;
				endcase
			end
			seg_left--;
			if ($urandom_range(0, 99) < push_pct)
				send_cmd(FUNC_PUSH, pick_value());
			else
				send_cmd(FUNC_POP, $signed($urandom()));
			if (n == RandomItems / 2)
				drain_results();
		end

		cmd_ch.valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
		repeat (TailCycles) @(posedge clk);

		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("tb_top: PASS");
		end else begin
			$display("tb_top: FAIL");
		end
		$finish;
	end

endmodule

`default_nettype wire

[files.f]
hdl/spq_pkg.sv
hdl/spq_chan_if.sv
hdl/spq_ctrl.sv
hdl/spq_datapath.sv
hdl/sorted_priority_queue_top.sv
verif/tb_top.sv
